// ===== sv/twtls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-way traffic light sequencer package
// Lamp and mode codes, reset timings and the transaction payload types.
// ----------------------------------------------------------------------------
package twtls_pkg;

  localparam logic [1:0] LAMP_RED    = 2'd0;
  localparam logic [1:0] LAMP_YELLOW = 2'd1;
  localparam logic [1:0] LAMP_GREEN  = 2'd2;

  localparam logic [1:0] MODE_AUTO      = 2'd0;
  localparam logic [1:0] MODE_MANUAL    = 2'd1;
  localparam logic [1:0] MODE_SET_RED   = 2'd2;
  localparam logic [1:0] MODE_SET_GREEN = 2'd3;

  localparam logic [6:0] DEFAULT_RED    = 7'd5;
  localparam logic [6:0] DEFAULT_GREEN  = 7'd3;
  localparam logic [6:0] DEFAULT_YELLOW = 7'd2;
  localparam logic [6:0] MAX_TIME       = 7'd99;

  typedef struct packed {
    logic [1:0] mode;
    logic       scan_tick;
    logic       second_tick;
    logic       next_press;
    logic       commit_press;
  } in_t;

  typedef struct packed {
    logic [1:0] lamp_a;
    logic [1:0] lamp_b;
    logic [6:0] shown_a;
    logic [6:0] shown_b;
    logic [3:0] digit_a;
    logic [3:0] digit_b;
    logic       digit_select;
    logic       committed;
  } out_t;

endpackage
`default_nettype wire

// ===== sv/twtls_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-way traffic light sequencer channels
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface twtls_in_if;
  logic              valid;
  logic              ready;
  twtls_pkg::in_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface twtls_out_if;
  logic              valid;
  logic              ready;
  twtls_pkg::out_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/two_way_traffic_light_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-way traffic light sequencer
// Sequences the lamps and countdowns of two directions, edits and commits
// the red and green times, and drives a two-digit multiplexed display.
//
// One input transaction (mode, scan and second ticks, two button presses)
// yields exactly one result transaction (both lamps, both shown values,
// the selected digit of each, the digit select and the commit flag).
// A transaction is captured in an input register and is processed into
// the result register once that register is empty or being read out.
// One transaction is taken per cycle while input ready is high; the state
// update and digit split are combinational compare, add and small
// constant multiply logic between those two registers.
// When the receiver stalls, the result register holds and the input
// register can still fill; input ready drops only when both are occupied.
// Reset clears both registers, puts A on red and B on green, loads the
// default times and sets both pending times to one.
// ----------------------------------------------------------------------------
module two_way_traffic_light_sequencer (
  input  wire         clk_i,
  input  wire         rst_ni,
  twtls_in_if.sink    in_i,
  twtls_out_if.source out_o
);
  import twtls_pkg::*;

  logic       s1_valid_q;
  in_t        s1_data_q;
  logic       out_valid_q;
  out_t       out_data_q;
  out_t       out_data_d;
  logic       s1_fire;

  logic [1:0] phase_a_q, phase_a_d, phase_b_q, phase_b_d;
  logic [6:0] count_a_q, count_a_d, count_b_q, count_b_d;
  logic [6:0] red_time_q, red_time_d, green_time_q, green_time_d;
  logic [6:0] yellow_time_q, yellow_time_d;
  logic [6:0] pend_red_q, pend_red_d, pend_green_q, pend_green_d;
  logic       scan_q, scan_d;

  function automatic logic [1:0] next_phase(logic [1:0] p);
    logic [1:0] r;
    r = LAMP_RED;
    if (p == LAMP_RED) r = LAMP_GREEN;
    else if (p == LAMP_GREEN) r = LAMP_YELLOW;
    return r;
  endfunction

  function automatic logic [3:0] tens_of(logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(logic [6:0] v);
    logic [6:0] t;
    t = 7'(tens_of(v)) * 7'd10;
    return 4'(v - t);
  endfunction

  assign s1_fire     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_fire;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    logic [1:0] ph;
    logic [7:0] bound;
    logic [7:0] pg_inc;
    logic [7:0] ydiff;
    logic [6:0] sa, sb;

    phase_a_d     = phase_a_q;
    phase_b_d     = phase_b_q;
    count_a_d     = count_a_q;
    count_b_d     = count_b_q;
    red_time_d    = red_time_q;
    green_time_d  = green_time_q;
    yellow_time_d = yellow_time_q;
    pend_red_d    = pend_red_q;
    pend_green_d  = pend_green_q;
    scan_d        = scan_q;
    out_data_d    = '0;
    ph            = LAMP_RED;
    bound         = 8'({1'b0, red_time_q}) - 8'({1'b0, yellow_time_q});
    pg_inc        = 8'({1'b0, pend_green_q}) + 8'd1;
    ydiff         = '0;

    if (s1_data_q.mode != MODE_MANUAL && s1_data_q.scan_tick) scan_d = !scan_q;

    case (s1_data_q.mode)
      MODE_AUTO: begin
        if (s1_data_q.second_tick) begin
          if (count_a_q <= 7'd1) begin
            ph        = next_phase(phase_a_q);
            phase_a_d = ph;
            count_a_d = (ph == LAMP_GREEN) ? green_time_q :
                        (ph == LAMP_YELLOW) ? yellow_time_q : red_time_q;
          end else begin
            count_a_d = count_a_q - 7'd1;
          end
          if (count_b_q <= 7'd1) begin
            ph        = next_phase(phase_b_q);
            phase_b_d = ph;
            count_b_d = (ph == LAMP_GREEN) ? green_time_q :
                        (ph == LAMP_YELLOW) ? yellow_time_q : red_time_q;
          end else begin
            count_b_d = count_b_q - 7'd1;
          end
        end
      end
      MODE_MANUAL: begin
        if (phase_a_q == LAMP_YELLOW) phase_a_d = LAMP_GREEN;
        if (phase_b_q == LAMP_YELLOW) phase_b_d = LAMP_GREEN;
        if (s1_data_q.next_press) begin
          if (phase_a_d == LAMP_RED) begin
            phase_a_d = LAMP_GREEN;
            phase_b_d = LAMP_RED;
          end else if (phase_a_d == LAMP_GREEN) begin
            phase_a_d = LAMP_RED;
            phase_b_d = LAMP_GREEN;
          end
        end
      end
      MODE_SET_RED: begin
        if (s1_data_q.next_press) begin
          pend_red_d = (pend_red_q >= MAX_TIME) ? 7'd1 : pend_red_q + 7'd1;
        end
        if (s1_data_q.commit_press) begin
          red_time_d           = pend_red_d;
          out_data_d.committed = 1'b1;
        end
      end
      default: begin
        if (s1_data_q.next_press) begin
          pend_green_d = ($signed(pg_inc) > $signed(bound)) ? 7'd1 : pg_inc[6:0];
        end
        if (s1_data_q.commit_press) begin
          green_time_d         = pend_green_d;
          ydiff                = 8'({1'b0, red_time_q}) - 8'({1'b0, pend_green_d});
          yellow_time_d        = ($signed(ydiff) < 8'sd1) ? 7'd1 : ydiff[6:0];
          out_data_d.committed = 1'b1;
        end
      end
    endcase

    if (s1_data_q.mode == MODE_SET_RED) begin
      out_data_d.lamp_a = LAMP_RED;
      out_data_d.lamp_b = LAMP_RED;
      sa                = pend_red_d;
      sb                = pend_red_d;
    end else if (s1_data_q.mode == MODE_SET_GREEN) begin
      out_data_d.lamp_a = LAMP_GREEN;
      out_data_d.lamp_b = LAMP_GREEN;
      sa                = pend_green_d;
      sb                = pend_green_d;
    end else begin
      out_data_d.lamp_a = phase_a_d;
      out_data_d.lamp_b = phase_b_d;
      sa                = count_a_d;
      sb                = count_b_d;
    end
    out_data_d.shown_a      = sa;
    out_data_d.shown_b      = sb;
    out_data_d.digit_a      = scan_d ? units_of(sa) : tens_of(sa);
    out_data_d.digit_b      = scan_d ? units_of(sb) : tens_of(sb);
    out_data_d.digit_select = scan_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_a_q     <= LAMP_RED;
      phase_b_q     <= LAMP_GREEN;
      count_a_q     <= DEFAULT_RED;
      count_b_q     <= DEFAULT_GREEN;
      red_time_q    <= DEFAULT_RED;
      green_time_q  <= DEFAULT_GREEN;
      yellow_time_q <= DEFAULT_YELLOW;
      pend_red_q    <= 7'd1;
      pend_green_q  <= 7'd1;
      scan_q        <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (s1_fire) begin
        out_valid_q   <= 1'b1;
        phase_a_q     <= phase_a_d;
        phase_b_q     <= phase_b_d;
        count_a_q     <= count_a_d;
        count_b_q     <= count_b_d;
        red_time_q    <= red_time_d;
        green_time_q  <= green_time_d;
        yellow_time_q <= yellow_time_d;
        pend_red_q    <= pend_red_d;
        pend_green_q  <= pend_green_d;
        scan_q        <= scan_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) s1_data_q <= in_i.data;
    if (s1_fire) out_data_q <= out_data_d;
  end

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_a_q != 7'd0 && count_b_q != 7'd0)
    else $error("countdown reached zero");

  a_yellow_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yellow_time_q != 7'd0)
    else $error("yellow time is zero");

  a_commit_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.committed |-> out_data_q.lamp_a == out_data_q.lamp_b)
    else $error("commit reported outside a set mode");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q && out_data_q.digit_select == scan_q)
    else $error("result register not loaded with the processed transaction");
`endif

endmodule
`default_nettype wire
